// ----- src/rsd_pkg.sv -----
// Shared types and constants of the radial spotlight dimmer.
package rsd_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 1'b1;

    // Field widths
    localparam int CENTER_W = 14;
    localparam int LUM_W    = 16;

    // Square root: 31-bit radicand (distance squared below the limit, scaled by 2^16),
    // 16-bit root in Q.8, two root bits resolved per pipeline stage
    localparam int RAD_W       = 32;
    localparam int ROOT_W      = 16;
    localparam int REM_W       = ROOT_W + 1;
    localparam int SQRT_ITERS  = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_ITERS;

    // Distance squared at or beyond 160^2 takes the floor factor
    localparam int LIM_SQ_W      = 15;
    localparam int DIST_LIMIT_SQ = 25600;

    // Factor is N / 51200; 51200 = 25 * 2^11
    localparam int FACTOR_W     = 16;
    localparam int FACTOR_DEN   = 51200;
    localparam int FACTOR_FLOOR = 10240;
    localparam int ROUND_HALF   = 25600;
    localparam int PROD_W       = LUM_W + FACTOR_W;
    localparam int DEN_SHIFT    = 11;
    localparam int DEN_ODD      = 25;
    localparam int XS_W         = PROD_W - DEN_SHIFT;

    // Divide by 25 through a reciprocal: floor(2^26 / 25), then one correction step
    localparam int RCP_W       = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_MULT  = 2684354;
    localparam int QM_W        = XS_W + RCP_W - RECIP_SHIFT;

    // Item travelling through the square root stages
    typedef struct packed {
        logic              far;
        logic [LUM_W-1:0]  lum;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sqrt_t;

endpackage

// ----- src/rsd_sqrt_stage.sv -----
// One registered stage of the digit-by-digit square root, two root bits per stage.
module rsd_sqrt_stage
    import rsd_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  sqrt_t sq_in,
    output sqrt_t sq_out
);

    sqrt_t                sq_reg;
    sqrt_t                sq_next;
    logic [REM_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
    logic [RAD_W-1:0]     rad;
    logic [REM_W+1:0]     acc;
    logic [ROOT_W+1:0]    trial;

    // Resolve two root bits: bring down a radicand pair, try to subtract 4*root+1
    always_comb begin
        rem   = sq_in.rem;
        root  = sq_in.root;
        rad   = sq_in.rad;
        acc   = '0;
        trial = '0;
        for (int i = 0; i < SQRT_ITERS; i++) begin
            acc   = {rem, rad[RAD_W-1 -: 2]};
            trial = {root, 2'b01};
            rad   = {rad[RAD_W-3:0], 2'b00};
            if (acc >= (REM_W+2)'(trial)) begin
                acc  = acc - (REM_W+2)'(trial);
                root = {root[ROOT_W-2:0], 1'b1};
            end else begin
                root = {root[ROOT_W-2:0], 1'b0};
            end
            rem = acc[REM_W-1:0];
        end
        sq_next      = sq_in;
        sq_next.rem  = rem;
        sq_next.root = root;
        sq_next.rad  = rad;
    end

    // Hold while the next stage is stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
        end
    end

    assign sq_out = sq_reg;

endmodule

// ----- src/radial_spotlight_dimmer.sv -----
// Top level of the radial spotlight dimmer: pixel pipeline and centre registers.
//
// Usage: pixels arrive on the s_ stream channel, one request per pixel, carrying
// column, row and Q0.16 luminance. Each pixel leaves on the m_ channel as one
// request with the dimmed luminance lum * f, f = 1 - 0.005 * distance from the
// configured centre, floored at 0.2, rounded to nearest.
// The centre is set through the cfg_ write port (index 0 column, index 1 row);
// the user must write it only while no pixel is in flight; no logic enforces this.
// The first of the 16 register stages loads at the edge that accepts an input
// request; m_tvalid is the valid bit of the last stage.
// Throughput: one pixel per cycle; the 16 register stages (three for distance
// squared, eight for the two-bits-per-stage square root, four for scaling and the
// divide by 51200, one output register) each take a new pixel every clock.
// Stalls: each stage holds its pixel only while it is full and the stage after it
// is blocked, so bubbles close up while m_tready is low and s_tready drops only
// once every stage is full. Nothing is lost or repeated.
// Reset: aresetn clears all stage valid bits and sets the centre to (0, 0).
module radial_spotlight_dimmer
    import rsd_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // Configuration writes
    input  logic                                        cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]                      cfg_index,
    input  logic [CENTER_W-1:0]                         cfg_wdata,
    // Pixel input
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // fields from bit 0: pixel_col, pixel_row, lum_in, zero fill
    input  logic [((2*COORD_BITS+LUM_W+7)/8)*8-1:0]     s_tdata,
    // Dimmed pixel output
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // fields from bit 0: lum_out
    output logic [LUM_W-1:0]                            m_tdata
);

    localparam int DX_W   = ((COORD_BITS + 1 > CENTER_W) ? COORD_BITS + 1 : CENTER_W) + 1;
    localparam int ADX_W  = DX_W - 1;
    localparam int SQ_W   = 2 * ADX_W;
    localparam int SUM_W  = SQ_W + 1;

    // Stage numbering
    localparam int ST_ABS   = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT0 = 3;
    localparam int ST_FAC   = ST_ROOT0 + SQRT_STAGES;
    localparam int ST_MUL   = ST_FAC + 1;
    localparam int ST_DIV   = ST_MUL + 1;
    localparam int ST_RCP   = ST_DIV + 1;
    localparam int ST_OUT   = ST_RCP + 1;
    localparam int NSTG     = ST_OUT + 1;

    logic [CENTER_W-1:0]    center_x_reg;
    logic [CENTER_W-1:0]    center_y_reg;
    logic [NSTG-1:0]        v_reg;
    logic [NSTG:0]          rdy;

    logic [COORD_BITS-1:0]  col;
    logic [COORD_BITS-1:0]  row;
    logic [LUM_W-1:0]       lum;
    logic [DX_W-1:0]        dx;
    logic [DX_W-1:0]        dy;
    logic [ADX_W-1:0]       adx_next;
    logic [ADX_W-1:0]       ady_next;
    logic [ADX_W-1:0]       adx_reg;
    logic [ADX_W-1:0]       ady_reg;
    logic [LUM_W-1:0]       lum1_reg;

    logic [SQ_W-1:0]        sqx_reg;
    logic [SQ_W-1:0]        sqy_reg;
    logic [LUM_W-1:0]       lum2_reg;

    logic [SUM_W-1:0]       sum;
    sqrt_t                  sq_init_next;
    sqrt_t                  sq_init_reg;
    sqrt_t                  sq_pipe [SQRT_STAGES+1];

    sqrt_t                  sq_done;
    logic [FACTOR_W-1:0]    nfac_reg;
    logic [LUM_W-1:0]       lum_f_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W:0]        prod_rnd;
    logic [XS_W-1:0]        xs_reg;
    logic [XS_W+RCP_W-1:0]  rcp_prod;
    logic [QM_W-1:0]        qm_reg;
    logic [XS_W-1:0]        xr_reg;
    logic [XS_W-1:0]        resid;
    logic [QM_W-1:0]        quot;
    logic [LUM_W-1:0]       lum_out_reg;

    // Write centre registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_X: center_x_reg <= cfg_wdata;
                REG_CENTER_Y: center_y_reg <= cfg_wdata;
            endcase
        end
    end

    // Ready chain: a stage loads when it is empty or its successor loads
    always_comb begin
        rdy[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_tready = rdy[0];

    // Stage 1: offsets from centre and their magnitudes
    assign col = s_tdata[COORD_BITS-1:0];
    assign row = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign lum = s_tdata[2*COORD_BITS +: LUM_W];

    always_comb begin
        dx = {{(DX_W-COORD_BITS){1'b0}}, col}
           - {{(DX_W-CENTER_W){center_x_reg[CENTER_W-1]}}, center_x_reg};
        dy = {{(DX_W-COORD_BITS){1'b0}}, row}
           - {{(DX_W-CENTER_W){center_y_reg[CENTER_W-1]}}, center_y_reg};
        adx_next = dx[DX_W-1] ? ADX_W'(-dx) : dx[ADX_W-1:0];
        ady_next = dy[DX_W-1] ? ADX_W'(-dy) : dy[ADX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_ABS]) begin
            adx_reg  <= adx_next;
            ady_reg  <= ady_next;
            lum1_reg <= lum;
        end
    end

    // Stage 2: squares
    always_ff @(posedge aclk) begin
        if (rdy[ST_SQ]) begin
            sqx_reg  <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
            sqy_reg  <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
            lum2_reg <= lum1_reg;
        end
    end

    // Stage 3: distance squared, floor check, radicand scaled by 2^16
    always_comb begin
        sum              = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        sq_init_next.far = (sum >= SUM_W'(DIST_LIMIT_SQ));
        sq_init_next.lum = lum2_reg;
        sq_init_next.rad = sq_init_next.far ? '0
                         : {{(RAD_W/2-LIM_SQ_W){1'b0}}, sum[LIM_SQ_W-1:0], {(RAD_W/2){1'b0}}};
        sq_init_next.root = '0;
        sq_init_next.rem  = '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_SUM]) begin
            sq_init_reg <= sq_init_next;
        end
    end

    assign sq_pipe[0] = sq_init_reg;

    // Square root stages
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_root
        rsd_sqrt_stage u_stage (
            .aclk   (aclk),
            .en     (rdy[ST_ROOT0+k]),
            .sq_in  (sq_pipe[k]),
            .sq_out (sq_pipe[k+1])
        );
    end

    assign sq_done = sq_pipe[SQRT_STAGES];

    // Factor numerator over 51200
    always_ff @(posedge aclk) begin
        if (rdy[ST_FAC]) begin
            nfac_reg  <= sq_done.far ? FACTOR_W'(FACTOR_FLOOR)
                                     : FACTOR_W'(FACTOR_DEN) - sq_done.root;
            lum_f_reg <= sq_done.lum;
        end
    end

    // Scale luminance
    always_ff @(posedge aclk) begin
        if (rdy[ST_MUL]) begin
            prod_reg <= PROD_W'(lum_f_reg) * PROD_W'(nfac_reg);
        end
    end

    // Add half the divisor, drop the power-of-two part of 51200
    assign prod_rnd = (PROD_W+1)'(prod_reg) + (PROD_W+1)'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (rdy[ST_DIV]) begin
            xs_reg <= prod_rnd[DEN_SHIFT +: XS_W];
        end
    end

    // Estimate the quotient by 25 through the reciprocal
    assign rcp_prod = (XS_W+RCP_W)'(xs_reg) * (XS_W+RCP_W)'(RECIP_MULT);

    always_ff @(posedge aclk) begin
        if (rdy[ST_RCP]) begin
            qm_reg <= rcp_prod[RECIP_SHIFT +: QM_W];
            xr_reg <= xs_reg;
        end
    end

    // Correct the estimate by at most one
    always_comb begin
        resid = xr_reg - XS_W'(XS_W'(qm_reg) * XS_W'(DEN_ODD));
        quot  = (resid >= XS_W'(DEN_ODD)) ? qm_reg + QM_W'(1) : qm_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            lum_out_reg <= quot[LUM_W-1:0];
        end
    end

    assign m_tvalid = v_reg[ST_OUT];
    assign m_tdata  = lum_out_reg;

endmodule

// ----- src/rsd_checker.sv -----
// Port-level checks of the radial spotlight dimmer and their binding.
module rsd_checker
    import rsd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [LUM_W-1:0] m_tdata
);

    // A stalled result request holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result request changed or dropped");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result request after reset");

    // With the receiver ready no stage can block the input
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while the receiver is ready");

    // A stalled result request stays valid while the input takes a request
    a_no_input_without_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tready && m_tvalid |=> m_tvalid)
        else $error("result request dropped while the input was taking requests");

endmodule

bind radial_spotlight_dimmer rsd_checker u_rsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/radial_spotlight_dimmer_test.sv -----
// Self-checking testbench for the radial spotlight dimmer pixel stream.
module radial_spotlight_dimmer_test
    import rsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS  = 12;
    localparam int S_DATA_W    = ((2*COORD_BITS+LUM_W+7)/8)*8;
    localparam int DIST_CAP_Q8 = 160 * 256;
    localparam int IDLE_PCT    = 18;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_WAIT  = 20;
    localparam int NUM_CASES   = 22;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_CENTER_X;
    logic [CENTER_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [LUM_W-1:0]      m_tdata;

    radial_spotlight_dimmer #(
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Pixel request awaiting its dimmed luminance
    typedef struct packed {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [LUM_W-1:0]      lum;
        logic [LUM_W-1:0]      dimmed;
    } dim_expect_t;

    // Directed case: centre, pixel, and a hand-worked result where one is obvious
    typedef struct packed {
        int cx;
        int cy;
        int col;
        int row;
        int lum;
        bit known;
        int want;
    } spot_case_t;

    spot_case_t spot_cases [NUM_CASES] = '{
        '{0, 0, 0, 0, 65535, 1'b1, 65535},        // on the centre, full scale
        '{0, 0, 0, 0, 0, 1'b1, 0},                // black stays black
        '{0, 0, 0, 0, 1, 1'b1, 1},
        '{0, 0, 100, 0, 65535, 1'b1, 32768},      // factor one half
        '{0, 0, 0, 100, 1, 1'b1, 1},              // exact half rounds up
        '{0, 0, 160, 0, 65535, 1'b1, 13107},      // distance exactly at the limit
        '{0, 0, 159, 0, 65535, 1'b0, 0},          // just inside the limit
        '{0, 0, 96, 128, 40000, 1'b1, 8000},      // diagonal at the limit
        '{0, 0, 3, 4, 43690, 1'b0, 0},
        '{0, 0, 4095, 4095, 65535, 1'b1, 13107},  // far corner, floor factor
        '{0, 0, 2730, 1365, 21845, 1'b0, 0},
        '{0, 0, 1365, 2730, 43690, 1'b0, 0},
        '{-8192, -8192, 0, 0, 65535, 1'b1, 13107}, // centre far outside the image
        '{-8192, -8192, 4095, 4095, 1, 1'b1, 0},
        '{8191, 8191, 4095, 4095, 65535, 1'b1, 13107},
        '{8191, 8191, 0, 0, 12345, 1'b0, 0},
        '{4095, 0, 4095, 0, 65535, 1'b1, 65535},
        '{4095, 0, 4095, 100, 65535, 1'b1, 32768},
        '{4200, -50, 4095, 0, 50000, 1'b0, 0},    // centre just off the edge
        '{2047, 2047, 2048, 2047, 65535, 1'b0, 0},
        '{2047, 2047, 2047, 2047, 32768, 1'b1, 32768},
        '{-1, -1, 0, 0, 65535, 1'b0, 0}
    };

    dim_expect_t                 dimmed_due [$];
    logic signed [CENTER_W-1:0]  centre_x = '0;
    logic signed [CENTER_W-1:0]  centre_y = '0;
    int                          idle_pct = IDLE_PCT;
    int                          mismatches = 0;
    int                          pixels_sent = 0;
    int                          pixels_seen = 0;
    int                          centres_used = 1;
    int                          within_radius = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Give up after a generous bound
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Distance from the centre in Q.8, truncated
    function automatic longint unsigned centre_dist_q8(input logic [COORD_BITS-1:0] col,
                                                       input logic [COORD_BITS-1:0] row);
        longint            dx;
        longint            dy;
        longint unsigned   rad;
        longint unsigned   root;
        longint unsigned   trial;
        begin
            dx   = longint'(col) - longint'(centre_x);
            dy   = longint'(row) - longint'(centre_y);
            rad  = longint'(dx * dx + dy * dy) << 16;
            root = 0;
            // Build the root one bit at a time, keeping root*root <= rad
            for (int b = 27; b >= 0; b--) begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= rad)
                    root = trial;
            end
            return root;
        end
    endfunction

    // Luminance after the spotlight factor, rounded to nearest
    function automatic logic [LUM_W-1:0] spotlight_lum(input logic [COORD_BITS-1:0] col,
                                                       input logic [COORD_BITS-1:0] row,
                                                       input logic [LUM_W-1:0] lum);
        longint unsigned dist_q8;
        longint unsigned factor;
        longint unsigned scaled;
        begin
            dist_q8 = centre_dist_q8(col, row);
            factor  = (dist_q8 < DIST_CAP_Q8) ? FACTOR_DEN - dist_q8 : FACTOR_FLOOR;
            if (factor < FACTOR_FLOOR)
                factor = FACTOR_FLOOR;
            scaled = (longint'(lum) * factor + ROUND_HALF) / FACTOR_DEN;
            if (scaled > 65535)
                scaled = 65535;
            return scaled[LUM_W-1:0];
        end
    endfunction

    // Drop s_tvalid and hold until every dimmed pixel has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (dimmed_due.size() != 0)
            @(posedge aclk);
    endtask

    // Move the spotlight centre; only done with the pipeline empty
    task automatic set_centre(input int x, input int y);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_CENTER_X;
        cfg_wdata <= CENTER_W'(x);
        @(posedge aclk);
        cfg_index <= REG_CENTER_Y;
        cfg_wdata <= CENTER_W'(y);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        centre_x = CENTER_W'(x);
        centre_y = CENTER_W'(y);
        centres_used++;
    endtask

    // Offer one pixel request and log its expected result once accepted
    task automatic send_pixel(input int col, input int row, input int lum,
                              input bit known, input int want);
        dim_expect_t exp_item;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({LUM_W'(lum), COORD_BITS'(row), COORD_BITS'(col)});
        do
            @(negedge aclk);
        while (!s_tready);
        @(posedge aclk);
        exp_item.col    = COORD_BITS'(col);
        exp_item.row    = COORD_BITS'(row);
        exp_item.lum    = LUM_W'(lum);
        exp_item.dimmed = known ? LUM_W'(want)
                                : spotlight_lum(exp_item.col, exp_item.row, exp_item.lum);
        if (centre_dist_q8(exp_item.col, exp_item.row) < DIST_CAP_Q8)
            within_radius++;
        dimmed_due.push_back(exp_item);
        pixels_sent++;
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Check each result request against the oldest pending pixel
    always @(negedge aclk) begin
        dim_expect_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (dimmed_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual lum_out %0d",
                         $time, m_tdata);
                mismatches++;
            end else begin
                head = dimmed_due.pop_front();
                pixels_seen++;
                if (m_tdata !== head.dimmed) begin
                    $display("%0t: lum_out mismatch for col %0d row %0d lum %0d centre (%0d,%0d): expected %0d, actual %0d",
                             $time, head.col, head.row, head.lum, centre_x, centre_y,
                             head.dimmed, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        int cx;
        int cy;
        int col;
        int row;
        int lum;
        int pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases, moving the centre only where a row asks for it
        foreach (spot_cases[i]) begin
            if (spot_cases[i].cx != int'(centre_x) || spot_cases[i].cy != int'(centre_y))
                set_centre(spot_cases[i].cx, spot_cases[i].cy);
            send_pixel(spot_cases[i].col, spot_cases[i].row, spot_cases[i].lum,
                       spot_cases[i].known, spot_cases[i].want);
        end

        // Random phases, each under a fresh centre
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 2) begin
                cx = int'($urandom_range(0, 16383)) - 8192;
                cy = int'($urandom_range(0, 16383)) - 8192;
            end else begin
                cx = $urandom_range(0, 4095);
                cy = $urandom_range(0, 4095);
            end
            set_centre(cx, cy);
            // one phase runs with no idling on either side
            idle_pct = (ph == 1) ? 0 : IDLE_PCT;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the sender until the pipeline has emptied
                if (n == PHASE_ITEMS / 2 && ph == 4)
                    settle();
                if ($urandom_range(0, 9) < 7) begin
                    col = int'(centre_x) + int'($urandom_range(0, 340)) - 170;
                    row = int'(centre_y) + int'($urandom_range(0, 340)) - 170;
                    col = (col < 0) ? 0 : (col > 4095) ? 4095 : col;
                    row = (row < 0) ? 0 : (row > 4095) ? 4095 : row;
                end else begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                pick = $urandom_range(0, 9);
                lum  = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535);
                send_pixel(col, row, lum, 1'b0, 0);
            end
        end

        // Wait for the tail, then let the pipeline run dry
        idle_pct = IDLE_PCT;
        settle();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d pixels under %0d centre positions, %0d inside the 160 pixel radius;",
                 pixels_sent, centres_used, within_radius);
        $display("%0d dimmed results checked, %0d mismatches.", pixels_seen, mismatches);
        if (mismatches == 0 && dimmed_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
